@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion on an implication, sampled at the rising clock edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Assertion on an implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hw/rtl/bclru_pkg.sv @@
`timescale 1ns / 1ps
package bclru_pkg;
  typedef enum logic [2:0] {
    FUNC_GET      = 3'd0,
    FUNC_RELEASE  = 3'd1,
    FUNC_DIRTY    = 3'd2,
    FUNC_SYNC_ONE = 3'd3,
    FUNC_SYNC_ALL = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_SLOT,
    ST_MODIFY,
    ST_OUT
  } state_e;

  localparam int unsigned IdW  = 64;
  localparam int unsigned CntW = 32;
  localparam logic [CntW-1:0] CntMax = '1;
endpackage

@@ hw/rtl/bclru_ram.sv @@
`timescale 1ns / 1ps
module bclru_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ hw/rtl/block_cache_lru_refcount.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Beat contents
// s_axis   in   tdata: func[2:0], tag[66:3], slot[74:67], zero fill to 80
// m_axis   out  tdata: result_slot[7:0], hit, failed, evicted, writeback_needed,
//               evicted_id[75:12], hit_total[107:76], miss_total[139:108], fill to 144
// Items are handled one at a time. A get streams the entries below the fill mark through
// the registered read port, then passes ST_WRITE and ST_OUT; sync all scans and goes to
// ST_OUT; release, mark dirty and sync one pass ST_SLOT, ST_MODIFY and ST_OUT; an unknown
// code goes straight to ST_OUT. Reset clears the fill mark, clock and counters but no entry,
// since every entry at or above the fill mark counts as empty. A result waits in the output
// register while m_axis_tready is low, and no input beat is taken until it has left.
`include "assert_macros.svh"
module block_cache_lru_refcount #(
  parameter int unsigned ENTRIES  = 256,
  parameter int unsigned REF_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,   // func, tag, slot
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata    // result_slot, hit, failed, evicted,
                                       // writeback_needed, evicted_id, hit_total,
                                       // miss_total
);
  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned IdW = bclru_pkg::IdW;
  localparam int unsigned CntW = bclru_pkg::CntW;
  // Entry word from the lowest bit up: tag, stamp, dirty, count.
  localparam int unsigned DirtyBit = 2 * IdW;
  localparam int unsigned EW = DirtyBit + 1 + REF_BITS;
  localparam logic [REF_BITS-1:0] RefMax = '1;
  localparam logic [AW:0] Full = (AW+1)'(ENTRIES);

  bclru_pkg::state_e   state_q, state_d;
  logic [2:0]          func_q;
  logic [IdW-1:0]      id_q;
  logic [7:0]          slot_q;
  logic [AW:0]         idx_q;        // next scan address to issue
  logic [AW-1:0]       ridx_q;       // address of the entry on the read port
  logic                rvld_q;
  logic [AW:0]         fill_q;
  logic [IdW-1:0]      clock_q;
  logic [CntW-1:0]     hits_q, misses_q;
  logic                found_q, have_q;
  logic [AW-1:0]       at_q, vic_q;
  logic                at_dirty_q, vic_dirty_q;
  logic [REF_BITS-1:0] at_refs_q;
  logic [IdW-1:0]      best_q, vic_tag_q;
  logic [7:0]          rslot_q;
  logic                hit_q, fail_q, evict_q, wb_q;
  logic [IdW-1:0]      eid_q;
  logic [143:0]        out_q;
  logic                ovld_q;

  logic [EW-1:0]       rd_data, wr_data;
  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [IdW-1:0]      rd_tag, rd_stamp;
  logic                rd_dirty;
  logic [REF_BITS-1:0] rd_refs;
  logic                accept, is_get, issue, tag_hit, scan_last, slot_ok;

  bclru_ram #(.Width(EW), .Depth(ENTRIES)) u_entry (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wr_data),
    .raddr_i(raddr), .rdata_o(rd_data));

  assign rd_tag   = rd_data[IdW-1:0];
  assign rd_stamp = rd_data[DirtyBit-1:IdW];
  assign rd_dirty = rd_data[DirtyBit];
  assign rd_refs  = rd_data[EW-1:DirtyBit+1];

  assign s_axis_tready = (state_q == bclru_pkg::ST_IDLE) && !ovld_q;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = out_q;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign is_get  = func_q == bclru_pkg::FUNC_GET;
  assign issue   = (state_q == bclru_pkg::ST_SCAN) && (idx_q < fill_q);
  assign tag_hit = rvld_q && is_get && (rd_tag == id_q);
  // The scan is over once the entry just below the fill mark has come back.
  assign scan_last = rvld_q && ((AW+1)'(ridx_q) + (AW+1)'(1) == fill_q);
  assign slot_ok   = 32'(slot_q) < 32'(fill_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bclru_pkg::ST_IDLE: begin
        if (accept) begin
          case (s_axis_tdata[2:0])
            bclru_pkg::FUNC_GET, bclru_pkg::FUNC_SYNC_ALL: state_d = bclru_pkg::ST_SCAN;
            bclru_pkg::FUNC_RELEASE, bclru_pkg::FUNC_DIRTY,
            bclru_pkg::FUNC_SYNC_ONE: state_d = bclru_pkg::ST_SLOT;
            default: state_d = bclru_pkg::ST_OUT;
          endcase
        end
      end
      bclru_pkg::ST_SCAN: begin
        if (fill_q == '0 || tag_hit || scan_last) begin
          if (is_get) state_d = bclru_pkg::ST_WRITE;
          else state_d = bclru_pkg::ST_OUT;
        end
      end
      bclru_pkg::ST_WRITE:  state_d = bclru_pkg::ST_OUT;
      bclru_pkg::ST_SLOT:   state_d = bclru_pkg::ST_MODIFY;
      bclru_pkg::ST_MODIFY: state_d = bclru_pkg::ST_OUT;
      bclru_pkg::ST_OUT:    state_d = bclru_pkg::ST_IDLE;
      default:              state_d = bclru_pkg::ST_IDLE;
    endcase
  end

  // Entry memory port control.
  always_comb begin
    raddr   = idx_q[AW-1:0];
    we      = 1'b0;
    waddr   = ridx_q;
    wr_data = rd_data;
    case (state_q)
      bclru_pkg::ST_SCAN: begin
        // Sync all cleans each dirty entry as it streams past.
        if (rvld_q && func_q == bclru_pkg::FUNC_SYNC_ALL && rd_dirty) begin
          we                = 1'b1;
          wr_data[DirtyBit] = 1'b0;
        end
      end
      bclru_pkg::ST_WRITE: begin
        wr_data = {REF_BITS'(1), 1'b0, clock_q + 64'd1, id_q};
        if (found_q) begin
          we      = 1'b1;
          waddr   = at_q;
          wr_data = {(at_refs_q != RefMax) ? at_refs_q + REF_BITS'(1) : at_refs_q,
                     at_dirty_q, clock_q + 64'd1, id_q};
        end else if (fill_q != Full) begin
          we    = 1'b1;
          waddr = fill_q[AW-1:0];
        end else if (have_q) begin
          we    = 1'b1;
          waddr = vic_q;
        end
      end
      bclru_pkg::ST_SLOT: raddr = AW'(slot_q);
      bclru_pkg::ST_MODIFY: begin
        waddr = AW'(slot_q);
        if (slot_ok) begin
          case (func_q)
            bclru_pkg::FUNC_RELEASE: begin
              if (rd_refs != '0) begin
                we                         = 1'b1;
                wr_data[EW-1:DirtyBit+1]   = rd_refs - REF_BITS'(1);
              end
            end
            bclru_pkg::FUNC_DIRTY: begin
              we                = 1'b1;
              wr_data[DirtyBit] = 1'b1;
            end
            default: begin
              if (rd_dirty) begin
                we                = 1'b1;
                wr_data[DirtyBit] = 1'b0;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bclru_pkg::ST_IDLE;
      func_q      <= '0;
      id_q        <= '0;
      slot_q      <= '0;
      idx_q       <= '0;
      ridx_q      <= '0;
      rvld_q      <= 1'b0;
      fill_q      <= '0;
      clock_q     <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      found_q     <= 1'b0;
      have_q      <= 1'b0;
      at_q        <= '0;
      vic_q       <= '0;
      at_dirty_q  <= 1'b0;
      vic_dirty_q <= 1'b0;
      at_refs_q   <= '0;
      best_q      <= '0;
      vic_tag_q   <= '0;
      rslot_q     <= '0;
      hit_q       <= 1'b0;
      fail_q      <= 1'b0;
      evict_q     <= 1'b0;
      wb_q        <= 1'b0;
      eid_q       <= '0;
      out_q       <= '0;
      ovld_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      rvld_q  <= issue;
      if (issue) begin
        idx_q  <= idx_q + (AW+1)'(1);
        ridx_q <= idx_q[AW-1:0];
      end
      if (state_q == bclru_pkg::ST_OUT) ovld_q <= 1'b1;
      else if (m_axis_tready) ovld_q <= 1'b0;
      case (state_q)
        bclru_pkg::ST_IDLE: begin
          if (accept) begin
            func_q  <= s_axis_tdata[2:0];
            id_q    <= s_axis_tdata[66:3];
            slot_q  <= s_axis_tdata[74:67];
            idx_q   <= '0;
            found_q <= 1'b0;
            have_q  <= 1'b0;
            rslot_q <= '0;
            hit_q   <= 1'b0;
            fail_q  <= 1'b0;
            evict_q <= 1'b0;
            wb_q    <= 1'b0;
            eid_q   <= '0;
          end
        end
        bclru_pkg::ST_SCAN: begin
          if (tag_hit) begin
            found_q    <= 1'b1;
            at_q       <= ridx_q;
            at_dirty_q <= rd_dirty;
            at_refs_q  <= rd_refs;
          end
          // The oldest unpinned entry is only used once the store is full.
          if (rvld_q && is_get && rd_refs == '0 && (!have_q || rd_stamp < best_q)) begin
            have_q      <= 1'b1;
            best_q      <= rd_stamp;
            vic_q       <= ridx_q;
            vic_tag_q   <= rd_tag;
            vic_dirty_q <= rd_dirty;
          end
          if (rvld_q && func_q == bclru_pkg::FUNC_SYNC_ALL && rd_dirty && !wb_q) begin
            wb_q  <= 1'b1;
            eid_q <= rd_tag;
          end
        end
        bclru_pkg::ST_WRITE: begin
          if (found_q) begin
            hit_q   <= 1'b1;
            rslot_q <= 8'(at_q);
            clock_q <= clock_q + 64'd1;
            if (hits_q != bclru_pkg::CntMax) hits_q <= hits_q + CntW'(1);
          end else begin
            if (misses_q != bclru_pkg::CntMax) misses_q <= misses_q + CntW'(1);
            if (fill_q != Full) begin
              rslot_q <= 8'(fill_q[AW-1:0]);
              fill_q  <= fill_q + (AW+1)'(1);
              clock_q <= clock_q + 64'd1;
            end else if (have_q) begin
              evict_q <= 1'b1;
              wb_q    <= vic_dirty_q;
              eid_q   <= vic_tag_q;
              rslot_q <= 8'(vic_q);
              clock_q <= clock_q + 64'd1;
            end else begin
              fail_q <= 1'b1;
            end
          end
        end
        bclru_pkg::ST_MODIFY: begin
          if (slot_ok && func_q == bclru_pkg::FUNC_SYNC_ONE && rd_dirty) begin
            wb_q  <= 1'b1;
            eid_q <= rd_tag;
          end
        end
        bclru_pkg::ST_OUT: begin
          out_q <= {4'd0, misses_q, hits_q, eid_q, wb_q, evict_q, fail_q, hit_q, rslot_q};
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, state_q != bclru_pkg::ST_IDLE,
    !s_axis_tready, "input accepted while busy")
  `ASSERT_NEXT(a_fill_mono, clk_i, rst_ni, 1'b1, fill_q >= $past(fill_q),
    "fill mark went down")
  `ASSERT_IMPL(a_fill_range, clk_i, rst_ni, 1'b1, fill_q <= Full, "fill mark too large")
  `ASSERT_IMPL(a_scan_range, clk_i, rst_ni, rvld_q, (AW+1)'(ridx_q) < fill_q,
    "scan read above the fill mark")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, ovld_q && !m_axis_tready,
    ovld_q && $stable(out_q), "result dropped under stall")
endmodule
